[src/fanout_list_table_assert.svh]
// assertion macros shared by the list table rtl
`ifndef FANOUT_LIST_TABLE_ASSERT_SVH
`define FANOUT_LIST_TABLE_ASSERT_SVH

// cond in the same cycle implies expr
`define FLT_ASSERT_IMP(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);

// cond implies expr in the next cycle
`define FLT_ASSERT_NXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

[src/fltab_pkg.sv]
// ----------------------------------------------------------------------------
// fltab_pkg
// types and constants for the fanout list table
// ----------------------------------------------------------------------------
`default_nettype none

package fltab_pkg;

  localparam int DEPTH_DEFAULT      = 16;
  localparam int ID_BITS_DEFAULT    = 16;
  localparam int INDEX_BITS_DEFAULT = 8;

  // field widths on the stream ports
  localparam int OP_W    = 3;
  localparam int IDF_W   = 16;
  localparam int IDXF_W  = 8;
  localparam int COUNT_W = 5;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 8;

  localparam int OP_LSB  = 0;
  localparam int ID_LSB  = OP_LSB + OP_W;
  localparam int IDX_LSB = ID_LSB + IDF_W;
  localparam int IN_USED = IDX_LSB + IDXF_W;

  localparam int OUT_USED = 1 + COUNT_W;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND      = 3'd0,
    OP_APPEND_NEW  = 3'd1,
    OP_POP         = 3'd2,
    OP_REMOVE_ID   = 3'd3,
    OP_REMOVE_PAIR = 3'd4,
    OP_CLEAR       = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_RESULT
  } state_t;

endpackage

`default_nettype wire

[src/fanout_list_table.sv]
// sequence: append and clear go from acceptance through the finish state to the result transaction;
// append-if-new, pop and both removes first pass through the scan state, as the
// single memory read port and comparator walk the list one entry per cycle
// throughput: one transaction in flight; the next is taken the cycle after the result leaves
// reset: rst (synchronous) empties the list; entry memory is not cleared
// ----------------------------------------------------------------------------
// fanout_list_table
// ordered list of element id / input index pairs with append, conditional
// append, pop, removal with compaction and clear
// ----------------------------------------------------------------------------
`default_nettype none

`include "fanout_list_table_assert.svh"

module fanout_list_table
  import fltab_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEFAULT,
  parameter int ID_BITS    = ID_BITS_DEFAULT,
  parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // op [2:0], element_id [18:3], input_index [26:19], zero [31:27]
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // ok [0], entry_count [5:1], zero [7:6]
  output logic [OUT_DATA_W-1:0]      m_tdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = ID_BITS + INDEX_BITS;
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  state_t state, state_next;

  op_t                  op_r;
  logic [ID_BITS-1:0]   id_r;
  logic [INDEX_BITS-1:0] idx_r;

  logic [CW-1:0] held_count;
  logic [CW-1:0] rd_addr;
  logic [CW-1:0] wr_ptr;
  logic          pend;
  logic          found;
  logic          ok_r;

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rdata;

  logic          issue;
  logic          hit;
  logic          fin_ok;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic          s_hs;

  assign s_hs = s_tvalid && s_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_hs) begin
          if (op_t'(s_tdata[OP_LSB +: OP_W]) inside
              {OP_APPEND_NEW, OP_POP, OP_REMOVE_ID, OP_REMOVE_PAIR}) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (!issue && !pend) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: state_next = ST_RESULT;
      ST_RESULT: begin
        if (m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and shared compare unit
  always_comb begin
    s_tready  = (state == ST_IDLE);
    m_tvalid  = (state == ST_RESULT);
    issue     = (state == ST_SCAN) && (rd_addr < held_count);
    hit       = 1'b0;
    fin_ok    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = wr_ptr[AW-1:0];
    mem_wdata = rdata;

    case (op_r)
      OP_POP:         hit = (rd_addr == CW'(1));
      OP_REMOVE_PAIR: hit = (rdata[ID_BITS-1:0] == id_r) &&
                            (rdata[EW-1:ID_BITS] == idx_r);
      default:        hit = (rdata[ID_BITS-1:0] == id_r);
    endcase

    case (op_r)
      OP_APPEND:      fin_ok = (held_count < FULL_COUNT);
      OP_APPEND_NEW:  fin_ok = !found && (held_count < FULL_COUNT);
      OP_POP,
      OP_REMOVE_ID,
      OP_REMOVE_PAIR: fin_ok = (wr_ptr != held_count);
      OP_CLEAR:       fin_ok = (held_count != '0);
      default:        fin_ok = 1'b0;
    endcase

    if (state == ST_SCAN) begin
      // compaction: keep entries that miss, packed down at the write pointer
      mem_we = pend && !hit && (op_r != OP_APPEND_NEW);
    end else if (state == ST_FINISH) begin
      mem_we    = fin_ok && (op_r == OP_APPEND || op_r == OP_APPEND_NEW);
      mem_waddr = held_count[AW-1:0];
      mem_wdata = {idx_r, id_r};
    end

    m_tdata = {{(OUT_DATA_W - OUT_USED){1'b0}}, COUNT_W'(held_count), ok_r};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[rd_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      held_count <= '0;
      pend       <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= issue;
      if (state == ST_FINISH) begin
        case (op_r)
          OP_APPEND,
          OP_APPEND_NEW: begin
            if (fin_ok) begin
              held_count <= held_count + CW'(1);
            end
          end
          OP_POP,
          OP_REMOVE_ID,
          OP_REMOVE_PAIR: held_count <= wr_ptr;
          OP_CLEAR:       held_count <= '0;
          default:        held_count <= held_count;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        op_r    <= op_t'(s_tdata[OP_LSB +: OP_W]);
        id_r    <= ID_BITS'(s_tdata[ID_LSB +: IDF_W]);
        idx_r   <= INDEX_BITS'(s_tdata[IDX_LSB +: IDXF_W]);
        rd_addr <= '0;
        wr_ptr  <= '0;
        found   <= 1'b0;
      end
      ST_SCAN: begin
        if (issue) begin
          rd_addr <= rd_addr + CW'(1);
        end
        if (pend && hit) begin
          found <= 1'b1;
        end
        if (mem_we) begin
          wr_ptr <= wr_ptr + CW'(1);
        end
      end
      ST_FINISH: ok_r <= fin_ok;
      default: begin
      end
    endcase
  end

  `FLT_ASSERT_IMP(a_count_bound, 1'b1, held_count <= FULL_COUNT, "list count above depth")
  `FLT_ASSERT_IMP(a_one_in_flight, m_tvalid, !s_tready, "input taken while result pending")
  `FLT_ASSERT_IMP(a_compact_order, (state == ST_SCAN) && mem_we, wr_ptr < rd_addr,
                  "compaction write overtook read")
  `FLT_ASSERT_NXT(a_result_follows, state == ST_FINISH, m_tvalid, "result not raised after finish")

endmodule

`default_nettype wire
